### rtl/qau_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and mode codes of the quaternion arithmetic unit.
// No dependencies; used by every other file of the block.
package qau_pkg;

  // Component format: signed two's complement with two integer bits.
  localparam int CW   = 16;
  localparam int FRAC = CW - 2;

  // Raw product of two components and the rounded form of it.
  localparam int PW  = 2 * CW;
  localparam int RW1 = CW + 2;
  // Sum of up to four rounded products (quaternion product, A, D, cross).
  localparam int SW  = CW + 4;
  // Raw and rounded product of a first-level sum with a component.
  localparam int P2W = SW + CW;
  localparam int R2W = P2W - FRAC;
  // Final pre-saturation sum, with headroom for the doubled rotate terms.
  localparam int FW  = CW + 9;

  typedef enum logic [1:0] {
    MODE_MUL  = 2'd0,
    MODE_ROT  = 2'd1,
    MODE_CONJ = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic signed [CW-1:0] a_w;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_w;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
  } qau_in_t;

  typedef struct packed {
    logic signed [CW-1:0] r_w;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    logic                 saturated;
  } qau_out_t;

endpackage

### rtl/qau_sat.sv
`timescale 1ns / 1ps
// Output saturation of the quaternion arithmetic unit: clips four wide
// sums to the component range and flags any clipping. Depends on qau_pkg.
module qau_sat (
  input  logic signed [qau_pkg::FW-1:0] fin_w,
  input  logic signed [qau_pkg::FW-1:0] fin_x,
  input  logic signed [qau_pkg::FW-1:0] fin_y,
  input  logic signed [qau_pkg::FW-1:0] fin_z,
  output qau_pkg::qau_out_t             res
);
  import qau_pkg::*;

  localparam logic signed [FW-1:0] SMAX = FW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [FW-1:0] SMIN = -SMAX - FW'(1);

  logic signed [FW-1:0] fin [4];
  logic signed [CW-1:0] clp [4];
  logic [3:0]           hit;

  assign fin[0] = fin_w;
  assign fin[1] = fin_x;
  assign fin[2] = fin_y;
  assign fin[3] = fin_z;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (fin[i] > SMAX) begin
        clp[i] = SMAX[CW-1:0];
        hit[i] = 1'b1;
      end else if (fin[i] < SMIN) begin
        clp[i] = SMIN[CW-1:0];
        hit[i] = 1'b1;
      end else begin
        clp[i] = fin[i][CW-1:0];
        hit[i] = 1'b0;
      end
    end
  end

  assign res.r_w       = clp[0];
  assign res.r_x       = clp[1];
  assign res.r_y       = clp[2];
  assign res.r_z       = clp[3];
  assign res.saturated = |hit;

endmodule

### rtl/quaternion_arithmetic_unit.sv
`timescale 1ns / 1ps
// Top level of the quaternion arithmetic unit: a five-stage pipeline for
// product, vector rotation and conjugate. Depends on qau_pkg and qau_sat.
//
//   channel | ports                          | direction | moves
//   --------+--------------------------------+-----------+-------------------
//   input   | in_valid, in_stall, in_req     | to block  | mode, a, b
//   result  | out_valid, out_stall, out_req  | from block| r, saturated flag
//
// A request accepted at a clock edge moves through stages 1 to 5 in order
// and raises out_valid once it sits in the stage 5 register.
// A new request can be accepted in every cycle while in_stall is low. The
// depth comes from the two rounds of multipliers, each followed by a
// round-and-sum stage, and a last saturation stage.
// Reset (rst_n low at a clock edge) clears all stage valid bits only.
// A stall on the result side holds the last stage; earlier stages keep
// moving into empty slots, so in_stall rises only when every stage is full.
module quaternion_arithmetic_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  qau_pkg::qau_in_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output qau_pkg::qau_out_t out_req
);
  import qau_pkg::*;

  localparam logic signed [PW:0]  HALF1 = (PW + 1)'(64'sd1 <<< (FRAC - 1));
  localparam logic signed [P2W:0] HALF2 = (P2W + 1)'(64'sd1 <<< (FRAC - 1));

  // Round to nearest, ties toward plus infinity, dropping FRAC bits.
  function automatic logic signed [RW1-1:0] rnd1(input logic signed [PW-1:0] p);
    logic signed [PW:0] t;
    t    = (PW + 1)'(p) + HALF1;
    rnd1 = RW1'(t >>> FRAC);
  endfunction

  function automatic logic signed [R2W-1:0] rnd2(input logic signed [P2W-1:0] p);
    logic signed [P2W:0] t;
    t    = (P2W + 1)'(p) + HALF2;
    rnd2 = R2W'(t >>> FRAC);
  endfunction

  // Stage handshake. A stage may load when it is empty or when the stage
  // after it is moving on in the same cycle.
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !s5_vld_r || !out_stall;
  assign rdy4 = !s4_vld_r || rdy5;
  assign rdy3 = !s3_vld_r || rdy4;
  assign rdy2 = !s2_vld_r || rdy3;
  assign rdy1 = !s1_vld_r || rdy2;

  assign in_stall  = !rdy1;
  assign out_valid = s5_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      if (rdy1) s1_vld_r <= in_valid;
      if (rdy2) s2_vld_r <= s1_vld_r;
      if (rdy3) s3_vld_r <= s2_vld_r;
      if (rdy4) s4_vld_r <= s3_vld_r;
      if (rdy5) s5_vld_r <= s4_vld_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: all sixteen cross products a_i*b_j and the four squares a_i^2.
  // Index 0 is the scalar part, 1 to 3 are i, j and k.
  logic signed [CW-1:0] in_a [4];
  logic signed [CW-1:0] in_b [4];
  logic signed [PW-1:0] ab_nxt [4][4];
  logic signed [PW-1:0] aa_nxt [4];

  assign in_a[0] = in_req.a_w;
  assign in_a[1] = in_req.a_x;
  assign in_a[2] = in_req.a_y;
  assign in_a[3] = in_req.a_z;
  assign in_b[0] = in_req.b_w;
  assign in_b[1] = in_req.b_x;
  assign in_b[2] = in_req.b_y;
  assign in_b[3] = in_req.b_z;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      aa_nxt[i] = PW'(in_a[i]) * PW'(in_a[i]);
      for (int j = 0; j < 4; j++) begin
        ab_nxt[i][j] = PW'(in_a[i]) * PW'(in_b[j]);
      end
    end
  end

  mode_t                s1_mode_r;
  logic signed [CW-1:0] s1_a_r [4];
  logic signed [CW-1:0] s1_v_r [3];
  logic signed [PW-1:0] s1_ab_r [4][4];
  logic signed [PW-1:0] s1_aa_r [4];

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_mode_r <= mode_t'(in_req.mode);
      s1_a_r    <= in_a;
      s1_v_r[0] <= in_req.b_x;
      s1_v_r[1] <= in_req.b_y;
      s1_v_r[2] <= in_req.b_z;
      s1_ab_r   <= ab_nxt;
      s1_aa_r   <= aa_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: round every product on its own and form the quaternion
  // product, together with the rotate terms A, D and x cross v.
  logic signed [RW1-1:0] rab [4][4];
  logic signed [RW1-1:0] raa [4];
  logic signed [SW-1:0]  q_nxt [4];
  logic signed [SW-1:0]  c_nxt [3];
  logic signed [SW-1:0]  a_sum_nxt, d_sum_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      raa[i] = rnd1(s1_aa_r[i]);
      for (int j = 0; j < 4; j++) begin
        rab[i][j] = rnd1(s1_ab_r[i][j]);
      end
    end
    q_nxt[0] = SW'(rab[0][0]) - SW'(rab[1][1]) - SW'(rab[2][2]) - SW'(rab[3][3]);
    q_nxt[1] = SW'(rab[0][1]) + SW'(rab[1][0]) + SW'(rab[2][3]) - SW'(rab[3][2]);
    q_nxt[2] = SW'(rab[0][2]) + SW'(rab[2][0]) + SW'(rab[3][1]) - SW'(rab[1][3]);
    q_nxt[3] = SW'(rab[0][3]) + SW'(rab[3][0]) + SW'(rab[1][2]) - SW'(rab[2][1]);
    a_sum_nxt = SW'(raa[0]) - SW'(raa[1]) - SW'(raa[2]) - SW'(raa[3]);
    d_sum_nxt = SW'(rab[1][1]) + SW'(rab[2][2]) + SW'(rab[3][3]);
    c_nxt[0]  = SW'(rab[2][3]) - SW'(rab[3][2]);
    c_nxt[1]  = SW'(rab[3][1]) - SW'(rab[1][3]);
    c_nxt[2]  = SW'(rab[1][2]) - SW'(rab[2][1]);
  end

  mode_t                s2_mode_r;
  logic signed [CW-1:0] s2_a_r [4];
  logic signed [CW-1:0] s2_v_r [3];
  logic signed [SW-1:0] s2_q_r [4];
  logic signed [SW-1:0] s2_c_r [3];
  logic signed [SW-1:0] s2_a_sum_r, s2_d_sum_r;

  always_ff @(posedge clk) begin
    if (rdy2 && s1_vld_r) begin
      s2_mode_r  <= s1_mode_r;
      s2_a_r     <= s1_a_r;
      s2_v_r     <= s1_v_r;
      s2_q_r     <= q_nxt;
      s2_c_r     <= c_nxt;
      s2_a_sum_r <= a_sum_nxt;
      s2_d_sum_r <= d_sum_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: second round of multipliers for rotation: A*v_k, D*x_k and
  // s*c_k, nine in all.
  logic signed [P2W-1:0] mav_nxt [3];
  logic signed [P2W-1:0] mdx_nxt [3];
  logic signed [P2W-1:0] msc_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mav_nxt[k] = P2W'(s2_a_sum_r) * P2W'(s2_v_r[k]);
      mdx_nxt[k] = P2W'(s2_d_sum_r) * P2W'(s2_a_r[k+1]);
      msc_nxt[k] = P2W'(s2_c_r[k]) * P2W'(s2_a_r[0]);
    end
  end

  mode_t                 s3_mode_r;
  logic signed [CW-1:0]  s3_a_r [4];
  logic signed [SW-1:0]  s3_q_r [4];
  logic signed [P2W-1:0] s3_mav_r [3];
  logic signed [P2W-1:0] s3_mdx_r [3];
  logic signed [P2W-1:0] s3_msc_r [3];

  always_ff @(posedge clk) begin
    if (rdy3 && s2_vld_r) begin
      s3_mode_r <= s2_mode_r;
      s3_a_r    <= s2_a_r;
      s3_q_r    <= s2_q_r;
      s3_mav_r  <= mav_nxt;
      s3_mdx_r  <= mdx_nxt;
      s3_msc_r  <= msc_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: round the rotate products, add them with the doubled terms,
  // and pick the result of the requested mode at full width. Negation of
  // the conjugate is done wide so that the most negative input saturates
  // in the next stage. The unused mode code gives zero.
  logic signed [FW-1:0] rot [3];
  logic signed [FW-1:0] fin_nxt [4];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rot[k] = FW'(rnd2(s3_mav_r[k]))
             + (FW'(rnd2(s3_mdx_r[k])) <<< 1)
             + (FW'(rnd2(s3_msc_r[k])) <<< 1);
    end
    case (s3_mode_r)
      MODE_MUL: begin
        for (int i = 0; i < 4; i++) fin_nxt[i] = FW'(s3_q_r[i]);
      end
      MODE_ROT: begin
        fin_nxt[0] = '0;
        for (int k = 0; k < 3; k++) fin_nxt[k+1] = rot[k];
      end
      MODE_CONJ: begin
        fin_nxt[0] = FW'(s3_a_r[0]);
        for (int k = 1; k < 4; k++) fin_nxt[k] = -FW'(s3_a_r[k]);
      end
      default: begin
        for (int i = 0; i < 4; i++) fin_nxt[i] = '0;
      end
    endcase
  end

  logic signed [FW-1:0] s4_fin_r [4];

  always_ff @(posedge clk) begin
    if (rdy4 && s3_vld_r) begin
      s4_fin_r <= fin_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: saturate to the component range into the output register.
  qau_out_t res_nxt;
  qau_out_t s5_res_r;

  qau_sat u_sat (
    .fin_w (s4_fin_r[0]),
    .fin_x (s4_fin_r[1]),
    .fin_y (s4_fin_r[2]),
    .fin_z (s4_fin_r[3]),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy5 && s4_vld_r) begin
      s5_res_r <= res_nxt;
    end
  end

  assign out_req = s5_res_r;

endmodule

### rtl/qau_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the quaternion arithmetic unit, bound to the top
// level. Depends on qau_pkg and quaternion_arithmetic_unit.
module qau_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input qau_pkg::qau_in_t  in_req,
  input logic              out_valid,
  input logic              out_stall,
  input qau_pkg::qau_out_t out_req
);
  import qau_pkg::*;

  // A stalled request on the input side waits unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_req))
    else $error("request changed or vanished while stalled");

  // A stalled result stays in place unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_req))
    else $error("result changed or vanished while stalled");

  // The input side only backs up when the result side is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side was free");

  // With a free result side, an accepted request reaches the output and raises out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      ##1 !out_stall |=> out_valid)
    else $error("request did not reach the output in five cycles");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (.*);
